FILE: hw/rtl/mmcd_pkg.sv
// Shared types and constants for the min/max column decimator.
// Holds request/point payload structs and the flush job carried by the queue.
// No dependencies.
package mmcd_pkg;

    localparam int INDEX_W     = 32;
    localparam int VALUE_W     = 32;
    localparam int X_W         = 16;
    localparam int TIME_W      = 48;
    localparam int KEPT_SLOTS  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Kept slot positions inside a bucket
    localparam int SLOT_FIRST = 0;
    localparam int SLOT_MIN   = 1;
    localparam int SLOT_MAX   = 2;
    localparam int SLOT_LAST  = 3;

    typedef struct packed {
        logic [INDEX_W-1:0]        sample_index;
        logic [TIME_W-1:0]         timestamp;
        logic signed [VALUE_W-1:0] sample_value;
        logic signed [X_W-1:0]     x_pos;
        logic                      ends_stream;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0]        point_index;
        logic signed [X_W-1:0]     point_x;
        logic signed [VALUE_W-1:0] point_value;
        logic                      polyline_end;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic [INDEX_W-1:0]        idx;
        logic signed [X_W-1:0]     x;
        logic signed [VALUE_W-1:0] val;
    } t_point;

    // One request's flushes: the old bucket and the end-of-stream bucket
    typedef struct packed {
        logic                         has_old;
        logic                         old_pend;
        t_point [KEPT_SLOTS-1:0]      old_pts;
        logic                         has_end;
        t_point [KEPT_SLOTS-1:0]      end_pts;
    } t_flush_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: hw/rtl/mmcd_front.sv
// Front end: accepts requests, tracks the column bucket and the time gap,
// and pushes flush jobs into the queue. Depends on mmcd_pkg.
module mmcd_front
    import mmcd_pkg::*;
#(
    parameter int X_FRAC_BITS  = 4,
    parameter int COLUMN_WIDTH = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TIME_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    input  t_q_status         i_q_status,
    output logic              o_q_push,
    output t_flush_job        o_q_job
);

    logic [TIME_W-1:0]                r_gap_thr;
    logic                             r_bucket_valid;
    logic [COLUMN_WIDTH-1:0]          r_bucket_col;
    t_point [KEPT_SLOTS-1:0]          r_pts;
    logic                             r_prev_time_valid;
    logic [TIME_W-1:0]                r_prev_time;

    logic                             w_accept;
    t_point                           w_pt;
    logic signed [X_W-1:0]            w_shift;
    logic [COLUMN_WIDTH-1:0]          w_col;
    logic                             w_gap;
    logic                             w_col_change;
    logic                             w_new_bucket;
    t_point [KEPT_SLOTS-1:0]          n_pts;

    assign o_in_stall = i_q_status.full;
    assign w_accept   = i_in_valid && !i_q_status.full;

    assign w_pt.idx = i_in_data.sample_index;
    assign w_pt.x   = i_in_data.x_pos;
    assign w_pt.val = i_in_data.sample_value;

    // Pixel column: floor of x, the arithmetic shift rounds toward minus infinity
    assign w_shift = i_in_data.x_pos >>> X_FRAC_BITS;
    assign w_col   = w_shift[COLUMN_WIDTH-1:0];

    // Gap break, only for a forward step above a nonzero threshold
    assign w_gap = r_prev_time_valid && (r_gap_thr != '0) &&
                   (i_in_data.timestamp > r_prev_time) &&
                   ((i_in_data.timestamp - r_prev_time) > r_gap_thr);

    assign w_col_change = (w_col != r_bucket_col);
    assign w_new_bucket = !r_bucket_valid || w_gap || w_col_change;

    // Bucket update; strict compares keep the earliest extreme
    always_comb begin
        if (w_new_bucket) begin
            n_pts = {KEPT_SLOTS{w_pt}};
        end else begin
            n_pts = r_pts;
            if ($signed(w_pt.val) < $signed(r_pts[SLOT_MIN].val)) begin
                n_pts[SLOT_MIN] = w_pt;
            end
            if ($signed(w_pt.val) > $signed(r_pts[SLOT_MAX].val)) begin
                n_pts[SLOT_MAX] = w_pt;
            end
            n_pts[SLOT_LAST] = w_pt;
        end
    end

    // Flush job for the queue
    always_comb begin
        o_q_job.has_old  = r_bucket_valid && (w_gap || w_col_change);
        o_q_job.old_pend = w_gap;
        o_q_job.old_pts  = r_pts;
        o_q_job.has_end  = i_in_data.ends_stream;
        o_q_job.end_pts  = n_pts;
    end

    assign o_q_push = w_accept && (o_q_job.has_old || o_q_job.has_end);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_thr         <= '0;
            r_bucket_valid    <= 1'b0;
            r_bucket_col      <= '0;
            r_prev_time_valid <= 1'b0;
            r_prev_time       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gap_thr <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_bucket_valid    <= !i_in_data.ends_stream;
                r_bucket_col      <= w_col;
                r_prev_time_valid <= !i_in_data.ends_stream;
                r_prev_time       <= i_in_data.timestamp;
            end
        end
    end

    // Kept points, read only while the bucket is valid
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pts <= n_pts;
        end
    end

endmodule

FILE: hw/rtl/mmcd_queue.sv
// Short job queue between the front end and the point emitter.
// Depends on mmcd_pkg.
module mmcd_queue
    import mmcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_flush_job i_job,
    input  logic       i_pop,
    output t_flush_job o_head,
    output t_q_status  o_status
);

    t_flush_job         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;

    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: hw/rtl/mmcd_back.sv
// Back end: takes queued flush jobs, orders kept points by index, drops
// repeats and emits one point per cycle unless stalled. Depends on mmcd_pkg.
module mmcd_back
    import mmcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_status,
    input  t_flush_job i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    localparam int ALL_SLOTS = 2 * KEPT_SLOTS;

    t_point [ALL_SLOTS-1:0]                         r_pts;
    logic                                           r_old_pend;
    logic [ALL_SLOTS-1:0]                           r_mask;
    logic [1:0][KEPT_SLOTS-1:0][KEPT_SLOTS-1:0]     r_lt;
    logic                                           r_out_valid;
    t_out_item                                      r_out;

    t_point [ALL_SLOTS-1:0]                         w_hpts;
    logic [ALL_SLOTS-1:0]                           w_ld_mask;
    logic [1:0][KEPT_SLOTS-1:0][KEPT_SLOTS-1:0]     w_ld_lt;
    logic                                           w_grp;
    logic [KEPT_SLOTS-1:0]                          w_gmask;
    logic [KEPT_SLOTS-1:0]                          w_gsel;
    logic [ALL_SLOTS-1:0]                           w_sel;
    logic [ALL_SLOTS-1:0]                           w_rest;
    t_point                                         w_point;
    logic                                           w_pend;
    logic                                           w_out_free;
    logic                                           w_emit;
    logic [ALL_SLOTS-1:0]                           n_mask;

    // Head job: old bucket in the low slots, end-of-stream bucket above
    assign w_hpts = {i_head.end_pts, i_head.old_pts};

    // Pairwise index order and repeat removal for the job at the head
    always_comb begin
        for (int g = 0; g < 2; g++) begin
            for (int i = 0; i < KEPT_SLOTS; i++) begin
                w_ld_mask[g*KEPT_SLOTS+i] = (g == 0) ? i_head.has_old : i_head.has_end;
                for (int j = 0; j < KEPT_SLOTS; j++) begin
                    w_ld_lt[g][i][j] = w_hpts[g*KEPT_SLOTS+i].idx <
                                       w_hpts[g*KEPT_SLOTS+j].idx;
                    if (j < i && w_hpts[g*KEPT_SLOTS+i].idx ==
                                 w_hpts[g*KEPT_SLOTS+j].idx) begin
                        w_ld_mask[g*KEPT_SLOTS+i] = 1'b0;
                    end
                end
            end
        end
    end

    // Pick the smallest remaining index, old bucket first
    assign w_grp   = (r_mask[KEPT_SLOTS-1:0] == '0);
    assign w_gmask = w_grp ? r_mask[ALL_SLOTS-1:KEPT_SLOTS] : r_mask[KEPT_SLOTS-1:0];

    always_comb begin
        for (int i = 0; i < KEPT_SLOTS; i++) begin
            w_gsel[i] = w_gmask[i];
            for (int j = 0; j < KEPT_SLOTS; j++) begin
                if (j != i && w_gmask[j] && !r_lt[w_grp][i][j]) begin
                    w_gsel[i] = 1'b0;
                end
            end
        end
    end

    assign w_sel  = w_grp ? {w_gsel, {KEPT_SLOTS{1'b0}}} : {{KEPT_SLOTS{1'b0}}, w_gsel};
    assign w_rest = r_mask & ~w_sel;

    always_comb begin
        w_point = '0;
        for (int k = 0; k < ALL_SLOTS; k++) begin
            if (w_sel[k]) begin
                w_point = r_pts[k];
            end
        end
    end

    // The end bucket always closes the polyline; the old one only on a gap
    assign w_pend = w_grp ? (w_rest[ALL_SLOTS-1:KEPT_SLOTS] == '0)
                          : (r_old_pend && (w_rest[KEPT_SLOTS-1:0] == '0));

    // Handshake toward the output register and the queue
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (|r_mask) && w_out_free;
    assign o_pop      = !i_status.empty && (!(|r_mask) || (w_emit && (w_rest == '0)));

    always_comb begin
        if (o_pop) begin
            n_mask = w_ld_mask;
        end else if (w_emit) begin
            n_mask = w_rest;
        end else begin
            n_mask = r_mask;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job payload and output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pts      <= w_hpts;
            r_old_pend <= i_head.old_pend;
            r_lt       <= w_ld_lt;
        end
        if (w_emit) begin
            r_out.point_index  <= w_point.idx;
            r_out.point_x      <= w_point.x;
            r_out.point_value  <= w_point.val;
            r_out.polyline_end <= w_pend;
            r_out.last         <= (w_rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // Exactly one kept point is chosen whenever a point goes out
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> $onehot(w_sel))
        else $error("emitter selected no point or several points");

    // Every job taken from the queue carries at least one point
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (|r_mask))
        else $error("job loaded without any kept point");

    // A point that is not the last of its request leaves more points behind
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (|r_mask))
        else $error("request ended without a last point");
`endif

endmodule

FILE: hw/rtl/min_max_column_decimator.sv
// A flush job is registered in the queue, then in the emitter's job registers,
// and its points leave through the output register, one per cycle while the
// output is not stalled. Throughput: one request per cycle while the four-job
// queue has room; the emitter sends up to five points per request.
// Reset: synchronous, active low; clears the bucket, time history, queue and
// output valid, and sets the gap threshold to zero.
module min_max_column_decimator
    import mmcd_pkg::*;
#(
    parameter int X_FRAC_BITS  = 4,
    parameter int COLUMN_WIDTH = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TIME_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    logic       w_push;
    logic       w_pop;
    t_flush_job w_job;
    t_flush_job w_head;
    t_q_status  w_q_status;

    // Request side: bucket tracking and flush detection
    mmcd_front #(
        .X_FRAC_BITS  (X_FRAC_BITS),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_q_status    (w_q_status),
        .o_q_push      (w_push),
        .o_q_job       (w_job)
    );

    // Flush jobs waiting for the emitter
    mmcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Point side: ordering and emission
    mmcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (w_q_status),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
